/* src/stokes_bandpass_normalizer_defines.svh */
// assertion macros for the stokes bandpass normalizer
`ifndef STOKES_BANDPASS_NORMALIZER_DEFINES_SVH
`define STOKES_BANDPASS_NORMALIZER_DEFINES_SVH
`ifndef SYNTH
`define SBN_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define SBN_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define SBN_ASSERT(lbl, ck, rn, prop, msg)
`define SBN_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

/* src/sbn_pkg.sv */
// shared constants, types and step functions for the stokes bandpass normalizer
package sbn_pkg;

	localparam int MAX_CHANNELS = 4096;
	localparam int CHAN_W       = 12;
	localparam int CNT_W        = 13;
	localparam int FRAC_BITS    = 16;
	localparam int SQRT_STEPS   = 33;
	localparam int DIV_STEPS    = 32;

	localparam logic [CNT_W-1:0] CHAN_COUNT_RST = 13'd4096;
	localparam logic [32:0]      ONE_FX         = 33'h0_0001_0000;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_PROC = 1'b1;

	// one lane of a restoring divider
	typedef struct packed {
		logic        neg;
		logic [32:0] den;
		logic [33:0] rem;
		logic [31:0] lo;
		logic [31:0] quo;
	} div_lane_t;

	// item state through the square root stages
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic              err;
		logic [32:0]       dr;
		logic [32:0]       dl;
		logic [3:0]        neg;
		logic [31:0]       mag_rr;
		logic [31:0]       mag_rl;
		logic [31:0]       mag_lr;
		logic [31:0]       mag_ll;
		logic [65:0]       rad;
		logic [35:0]       srem;
		logic [32:0]       root;
	} sq_stage_t;

	// item state through the divider stages (lanes: rr, rl, lr, ll)
	typedef struct packed {
		logic [CHAN_W-1:0]     chan;
		logic                  err;
		logic [32:0]           root;
		div_lane_t [3:0]       lane;
	} div_stage_t;

	// one bit of the integer square root
	function automatic sq_stage_t sqrt_step(input sq_stage_t s);
		sq_stage_t  o;
		logic [35:0] r;
		logic [35:0] trial;
		o     = s;
		r     = {s.srem[33:0], s.rad[65:64]};
		trial = {1'b0, s.root, 2'b01};
		o.rad = {s.rad[63:0], 2'b00};
		if (r >= trial) begin
			o.srem = r - trial;
			o.root = {s.root[31:0], 1'b1};
		end else begin
			o.srem = r;
			o.root = {s.root[31:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of a restoring divider
	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t   o;
		logic [33:0] r;
		o    = l;
		r    = {l.rem[32:0], l.lo[31]};
		o.lo = {l.lo[30:0], 1'b0};
		if (r >= {1'b0, l.den}) begin
			o.rem = r - {1'b0, l.den};
			o.quo = {l.quo[30:0], 1'b1};
		end else begin
			o.rem = r;
			o.quo = {l.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	// apply sign to an unsigned quotient
	function automatic logic signed [33:0] apply_sign(input logic neg, input logic [31:0] q);
		logic signed [33:0] v;
		v = signed'({2'b00, q});
		return neg ? -v : v;
	endfunction

	// clamp to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -35'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

/* src/sbn_if.sv */
// handshake channels of the stokes bandpass normalizer
interface sbn_in_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [sbn_pkg::CHAN_W-1:0] chan_index;
	logic [31:0]                band_r;
	logic [31:0]                band_l;
	logic signed [31:0]         corr_rr;
	logic signed [31:0]         corr_rl;
	logic signed [31:0]         corr_lr;
	logic signed [31:0]         corr_ll;
	modport source (output valid, action, chan_index, band_r, band_l,
		corr_rr, corr_rl, corr_lr, corr_ll, input ready);
	modport sink (input valid, action, chan_index, band_r, band_l,
		corr_rr, corr_rl, corr_lr, corr_ll, output ready);
endinterface

interface sbn_out_if;
	logic                       valid;
	logic                       ready;
	logic signed [31:0]         stokes_i;
	logic signed [31:0]         stokes_q;
	logic signed [31:0]         stokes_u;
	logic signed [31:0]         stokes_v;
	logic [sbn_pkg::CHAN_W-1:0] chan_out;
	logic                       range_error;
	modport source (output valid, stokes_i, stokes_q, stokes_u, stokes_v,
		chan_out, range_error, input ready);
	modport sink (input valid, stokes_i, stokes_q, stokes_u, stokes_v,
		chan_out, range_error, output ready);
endinterface

interface sbn_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [sbn_pkg::CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/stokes_bandpass_normalizer.sv */
// stokes bandpass normalizer: table lookup, product, square root and divider pipeline
// Stages from transaction accept to result valid: input stage, product stage, the
// 33-stage square root, the 32-stage divider (one bit per stage), output register.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset: arst_n clears valid bits and sets chan_count to 4096; band tables are
// not cleared and must be loaded before a channel is processed.
`include "stokes_bandpass_normalizer_defines.svh"

module stokes_bandpass_normalizer (
	input logic      clk,
	input logic      arst_n,
	sbn_in_if.sink   samples,
	sbn_cfg_if.sink  cfg,
	sbn_out_if.source results
);

	logic                        en;
	logic                        acc;
	logic [sbn_pkg::CNT_W-1:0]   chan_count_q;

	logic [31:0] band_r_mem [sbn_pkg::MAX_CHANNELS];
	logic [31:0] band_l_mem [sbn_pkg::MAX_CHANNELS];

	logic                        v_s1;
	logic [31:0]                 br_s1, bl_s1;
	logic [sbn_pkg::CHAN_W-1:0]  chan_s1;
	logic                        err_s1;
	logic [3:0]                  neg_s1;
	logic [31:0]                 mrr_s1, mrl_s1, mlr_s1, mll_s1;

	logic                        v_s2;
	sbn_pkg::sq_stage_t          sq0_s2;
	logic [32:0]                 dr, dl;
	logic [65:0]                 prod;

	logic [sbn_pkg::SQRT_STEPS:0] sq_v;
	sbn_pkg::sq_stage_t           sq_sn [sbn_pkg::SQRT_STEPS+1];
	logic [sbn_pkg::DIV_STEPS:0]  dv_v;
	sbn_pkg::div_stage_t          dv_sn [sbn_pkg::DIV_STEPS+1];

	sbn_pkg::sq_stage_t           sq_end;
	sbn_pkg::div_stage_t          dv_end;
	logic signed [33:0]           qa, qb, qq, qu;

	// pipeline advances unless a finished result is stalled
	assign en            = !results.valid || results.ready;
	assign samples.ready = en;
	assign acc           = samples.valid && en;
	assign cfg.ready     = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= sbn_pkg::CHAN_COUNT_RST;
		end else if (cfg.valid) begin
			chan_count_q <= cfg.data;
		end
	end

	// band tables: write on load, registered read on every transaction
	always_ff @(posedge clk) begin
		if (acc && samples.action == sbn_pkg::ACT_LOAD) begin
			band_r_mem[samples.chan_index] <= samples.band_r;
			band_l_mem[samples.chan_index] <= samples.band_l;
		end
		if (acc) begin
			br_s1 <= band_r_mem[samples.chan_index];
			bl_s1 <= band_l_mem[samples.chan_index];
		end
	end

	// stage 1: capture sample, signs and magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= samples.valid && samples.action == sbn_pkg::ACT_PROC;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			chan_s1 <= samples.chan_index;
			err_s1  <= {1'b0, samples.chan_index} >= chan_count_q;
			neg_s1  <= {samples.corr_rr[31], samples.corr_rl[31],
				samples.corr_lr[31], samples.corr_ll[31]};
			mrr_s1  <= samples.corr_rr[31] ? 32'(-samples.corr_rr) : 32'(samples.corr_rr);
			mrl_s1  <= samples.corr_rl[31] ? 32'(-samples.corr_rl) : 32'(samples.corr_rl);
			mlr_s1  <= samples.corr_lr[31] ? 32'(-samples.corr_lr) : 32'(samples.corr_lr);
			mll_s1  <= samples.corr_ll[31] ? 32'(-samples.corr_ll) : 32'(samples.corr_ll);
		end
	end

	// stage 2: offset bandshapes and their product (one 32x32 multiply plus corrections)
	always_comb begin
		dr   = {1'b0, br_s1} + sbn_pkg::ONE_FX;
		dl   = {1'b0, bl_s1} + sbn_pkg::ONE_FX;
		prod = 66'(dr[31:0]) * 66'(dl[31:0]);
		if (dr[32])
			prod = prod + {1'b0, dl, 32'h0};
		if (dl[32])
			prod = prod + {2'b00, dr[31:0], 32'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq0_s2.chan   <= chan_s1;
			sq0_s2.err    <= err_s1;
			sq0_s2.dr     <= dr;
			sq0_s2.dl     <= dl;
			sq0_s2.neg    <= neg_s1;
			sq0_s2.mag_rr <= mrr_s1;
			sq0_s2.mag_rl <= mrl_s1;
			sq0_s2.mag_lr <= mlr_s1;
			sq0_s2.mag_ll <= mll_s1;
			sq0_s2.rad    <= prod;
			sq0_s2.srem   <= '0;
			sq0_s2.root   <= '0;
		end
	end

	assign sq_v[0]  = v_s2;
	assign sq_sn[0] = sq0_s2;

	// square root stages, one result bit each
	for (genvar k = 0; k < sbn_pkg::SQRT_STEPS; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_sn[k+1] <= sbn_pkg::sqrt_step(sq_sn[k]);
			end
		end
	end

	// divider setup: numerators pre-shifted; -2^31 over a root of 1.0 exceeds 32 bits
	assign sq_end = sq_sn[sbn_pkg::SQRT_STEPS];
	always_comb begin
		dv_v[0]          = sq_v[sbn_pkg::SQRT_STEPS];
		dv_sn[0].chan    = sq_end.chan;
		dv_sn[0].err     = sq_end.err;
		dv_sn[0].root    = sq_end.root;
		dv_sn[0].lane[3] = '{neg: sq_end.neg[3], den: sq_end.dr,
			rem: {18'h0, sq_end.mag_rr[31:16]}, lo: {sq_end.mag_rr[15:0], 16'h0}, quo: '0};
		dv_sn[0].lane[2] = '{neg: sq_end.neg[2], den: sq_end.root,
			rem: {17'h0, sq_end.mag_rl[31:15]}, lo: {sq_end.mag_rl[14:0], 17'h0}, quo: '0};
		dv_sn[0].lane[1] = '{neg: sq_end.neg[1], den: sq_end.root,
			rem: {17'h0, sq_end.mag_lr[31:15]}, lo: {sq_end.mag_lr[14:0], 17'h0}, quo: '0};
		dv_sn[0].lane[0] = '{neg: sq_end.neg[0], den: sq_end.dl,
			rem: {18'h0, sq_end.mag_ll[31:16]}, lo: {sq_end.mag_ll[15:0], 16'h0}, quo: '0};
	end

	// divider stages, one quotient bit per lane each
	for (genvar k = 0; k < sbn_pkg::DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (en) begin
				dv_v[k+1] <= dv_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_sn[k+1].chan <= dv_sn[k].chan;
				dv_sn[k+1].err  <= dv_sn[k].err;
				dv_sn[k+1].root <= dv_sn[k].root;
				for (int j = 0; j < 4; j++) begin
					dv_sn[k+1].lane[j] <= sbn_pkg::div_step(dv_sn[k].lane[j]);
				end
			end
		end
	end

	// signed quotients
	assign dv_end = dv_sn[sbn_pkg::DIV_STEPS];
	assign qa = sbn_pkg::apply_sign(dv_end.lane[3].neg, dv_end.lane[3].quo);
	assign qq = sbn_pkg::apply_sign(dv_end.lane[2].neg, dv_end.lane[2].quo);
	assign qu = sbn_pkg::apply_sign(dv_end.lane[1].neg, dv_end.lane[1].quo);
	assign qb = sbn_pkg::apply_sign(dv_end.lane[0].neg, dv_end.lane[0].quo);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (en) begin
			results.valid <= dv_v[sbn_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			results.chan_out    <= dv_end.chan;
			results.range_error <= dv_end.err;
			if (dv_end.err) begin
				results.stokes_i <= '0;
				results.stokes_q <= '0;
				results.stokes_u <= '0;
				results.stokes_v <= '0;
			end else begin
				results.stokes_i <= sbn_pkg::sat32(35'(qa) + 35'(qb));
				results.stokes_v <= sbn_pkg::sat32(35'(qa) - 35'(qb));
				results.stokes_q <= sbn_pkg::sat32(35'(qq));
				results.stokes_u <= sbn_pkg::sat32(35'(qu));
			end
		end
	end

	// checks
	`SBN_ASSERT(a_load_no_result, clk, arst_n, (acc && samples.action == sbn_pkg::ACT_LOAD) |=> !v_s1, "load transaction entered result pipeline")
	`SBN_ASSERT(a_err_zero, clk, arst_n, (results.valid && results.range_error) |-> (results.stokes_i == 0 && results.stokes_q == 0 && results.stokes_u == 0 && results.stokes_v == 0), "range error result not zero")
	`SBN_ASSERT(a_root_min, clk, arst_n, dv_v[0] |-> (sq_end.root[32:16] != 17'h0), "square root below one")
	`SBN_ASSERT(a_stall_hold, clk, arst_n, (results.valid && !results.ready) |=> $stable(dv_v), "pipeline moved while stalled")
	`SBN_ASSERT_ALWAYS(a_cfg_ready, clk, cfg.ready, "configuration port not ready")

endmodule

/* sim/stokes_bandpass_normalizer_tb.sv */
// self-checking testbench for the stokes bandpass normalizer
module stokes_bandpass_normalizer_tb;

	typedef struct {
		logic                       action;
		logic [sbn_pkg::CHAN_W-1:0] chan;
		logic [31:0]                band_r;
		logic [31:0]                band_l;
		logic [31:0]                rr;
		logic [31:0]                rl;
		logic [31:0]                lr;
		logic [31:0]                ll;
		bit                         typed;
		logic [31:0]                i_val;
		logic [31:0]                q_val;
		logic [31:0]                u_val;
		logic [31:0]                v_val;
		logic                       err;
	} spec_row_t;

	typedef struct {
		logic [31:0]                i_val;
		logic [31:0]                q_val;
		logic [31:0]                u_val;
		logic [31:0]                v_val;
		logic [sbn_pkg::CHAN_W-1:0] chan;
		logic                       err;
	} stokes_t;

	logic clk;
	logic arst_n;
	sbn_in_if  in_ch();
	sbn_cfg_if cfg_ch();
	sbn_out_if out_ch();

	stokes_bandpass_normalizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.cfg(cfg_ch),
		.results(out_ch)
	);

	// predictor state
	logic [31:0]                band_r_mem [sbn_pkg::MAX_CHANNELS];
	logic [31:0]                band_l_mem [sbn_pkg::MAX_CHANNELS];
	logic [sbn_pkg::CNT_W-1:0]  active_chans;
	logic [sbn_pkg::CHAN_W-1:0] loaded_chans [$];
	bit                         loaded [sbn_pkg::MAX_CHANNELS];
	stokes_t                    pending_stokes [$];
	int                         fails;
	bit                         quiet_out;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// signed Q16.16 quotient, truncated toward zero
	function automatic longint fx_quot(input longint num, input int sh,
			input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (mag << sh) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// floor of sqrt(a*b)
	function automatic longint unsigned geo_root(input logic [32:0] a, input logic [32:0] b);
		logic [67:0] prod;
		logic [67:0] t;
		logic [67:0] s;
		prod = 68'(a) * 68'(b);
		s = '0;
		for (int k = 32; k >= 0; k--) begin
			t = s | (68'd1 << k);
			if (t * t <= prod)
				s = t;
		end
		return longint'(s);
	endfunction

	function automatic stokes_t predict_stokes(input spec_row_t r);
		stokes_t o;
		longint unsigned dr;
		longint unsigned dl;
		longint unsigned root;
		longint a;
		longint b;
		o = '{default: '0};
		o.chan = r.chan;
		if (r.chan >= active_chans) begin
			o.err = 1'b1;
			return o;
		end
		dr = longint'(band_r_mem[r.chan]) + 65536;
		dl = longint'(band_l_mem[r.chan]) + 65536;
		root = geo_root(dr[32:0], dl[32:0]);
		a = fx_quot(longint'(signed'(r.rr)), sbn_pkg::FRAC_BITS, dr);
		b = fx_quot(longint'(signed'(r.ll)), sbn_pkg::FRAC_BITS, dl);
		o.i_val = clamp32(a + b);
		o.v_val = clamp32(a - b);
		o.q_val = clamp32(fx_quot(longint'(signed'(r.rl)), sbn_pkg::FRAC_BITS + 1, root));
		o.u_val = clamp32(fx_quot(longint'(signed'(r.lr)), sbn_pkg::FRAC_BITS + 1, root));
		return o;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one item and wait for its transaction
	task automatic send_item(input spec_row_t r, input bit gaps);
		stokes_t e;
		int n;
		n = gaps ? idle_len() : 0;
		repeat (n) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid      = 1'b1;
		in_ch.action     = r.action;
		in_ch.chan_index = r.chan;
		in_ch.band_r     = r.band_r;
		in_ch.band_l     = r.band_l;
		in_ch.corr_rr    = r.rr;
		in_ch.corr_rl    = r.rl;
		in_ch.corr_lr    = r.lr;
		in_ch.corr_ll    = r.ll;
		do @(posedge clk); while (!in_ch.ready);
		if (r.action == sbn_pkg::ACT_LOAD) begin
			band_r_mem[r.chan] = r.band_r;
			band_l_mem[r.chan] = r.band_l;
			if (!loaded[r.chan]) begin
				loaded[r.chan] = 1'b1;
				loaded_chans.push_back(r.chan);
			end
		end else begin
			e = predict_stokes(r);
			if (r.typed) begin
				e.i_val = r.i_val;
				e.q_val = r.q_val;
				e.u_val = r.u_val;
				e.v_val = r.v_val;
				e.err   = r.err;
			end
			pending_stokes.push_back(e);
		end
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_stokes.size() != 0)
			@(negedge clk);
	endtask

	// channel count write, only with the pipeline empty
	task automatic write_chan_count(input logic [sbn_pkg::CNT_W-1:0] cnt);
		drain();
		repeat (80) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = cnt;
		do @(posedge clk); while (!cfg_ch.ready);
		active_chans = cnt;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return $urandom_range(0, 32'h0003_FFFF);
			default: return $urandom();
		endcase
	endfunction

	function automatic spec_row_t rand_item();
		spec_row_t r;
		r = '{default: '0};
		if (loaded_chans.size() == 0 || $urandom_range(0, 99) < 35) begin
			r.action = sbn_pkg::ACT_LOAD;
			r.chan   = 12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom());
			r.band_r = rand_word();
			r.band_l = rand_word();
			r.rr = $urandom(); r.rl = $urandom(); r.lr = $urandom(); r.ll = $urandom();
		end else begin
			r.action = sbn_pkg::ACT_PROC;
			r.chan   = loaded_chans[$urandom_range(0, loaded_chans.size() - 1)];
			r.band_r = $urandom();
			r.band_l = $urandom();
			r.rr = rand_word(); r.rl = rand_word(); r.lr = rand_word(); r.ll = rand_word();
		end
		return r;
	endfunction

	// directed table: action, chan, band_r, band_l, rr, rl, lr, ll, typed, i, q, u, v, err
	spec_row_t directed [] = '{
		'{sbn_pkg::ACT_LOAD, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0001_0000, 1'b1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
			32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 32'h2, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0},
		'{sbn_pkg::ACT_LOAD, 12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
			32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd4095, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
		'{sbn_pkg::ACT_LOAD, 12'd2047, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd2047, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_LOAD, 12'd2048, 32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0,
			32'h0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd2048, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 32'h0, 32'h0,
			1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1},
		'{sbn_pkg::ACT_LOAD, 12'd5, 32'h0000_0001, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd5, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0005_5555, 32'hFFFA_AAAB,
			32'h0000_0001, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_LOAD, 12'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
			1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
		'{sbn_pkg::ACT_PROC, 12'd5, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}
	};

	// result ready with random stalls, mostly short and a few long
	initial begin
		int n;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_out && $urandom_range(0, 2) == 0) begin
				n = idle_len();
				out_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ch.ready = 1'b1;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		stokes_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_stokes.size() == 0) begin
				$display("%0t: unexpected result chan %0d", $time, out_ch.chan_out);
				fails++;
			end else begin
				e = pending_stokes.pop_front();
				if (out_ch.stokes_i !== e.i_val) begin
					$display("%0t: stokes_i exp %h got %h", $time, e.i_val, out_ch.stokes_i);
					fails++;
				end
				if (out_ch.stokes_q !== e.q_val) begin
					$display("%0t: stokes_q exp %h got %h", $time, e.q_val, out_ch.stokes_q);
					fails++;
				end
				if (out_ch.stokes_u !== e.u_val) begin
					$display("%0t: stokes_u exp %h got %h", $time, e.u_val, out_ch.stokes_u);
					fails++;
				end
				if (out_ch.stokes_v !== e.v_val) begin
					$display("%0t: stokes_v exp %h got %h", $time, e.v_val, out_ch.stokes_v);
					fails++;
				end
				if (out_ch.chan_out !== e.chan) begin
					$display("%0t: chan_out exp %0d got %0d", $time, e.chan, out_ch.chan_out);
					fails++;
				end
				if (out_ch.range_error !== e.err) begin
					$display("%0t: range_error exp %b got %b", $time, e.err,
						out_ch.range_error);
					fails++;
				end
			end
		end
	end

	// run limit
	initial begin
		#5000000;
		$display("stokes_bandpass_normalizer_tb NOT OK");
		$finish;
	end

	// stimulus
	initial begin
		logic [sbn_pkg::CNT_W-1:0] counts [4];
		int wait_cycles;
		fails = 0;
		quiet_out = 1'b0;
		active_chans = sbn_pkg::CHAN_COUNT_RST;
		in_ch.valid = 1'b0;
		in_ch.action = sbn_pkg::ACT_LOAD;
		in_ch.chan_index = '0;
		in_ch.band_r = '0;
		in_ch.band_l = '0;
		in_ch.corr_rr = '0;
		in_ch.corr_rl = '0;
		in_ch.corr_lr = '0;
		in_ch.corr_ll = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_chan_count(13'd2048);
		foreach (directed[k])
			send_item(directed[k], 1'b1);

		// sender holds until the pipeline has emptied
		drain();

		counts = '{13'd4096, 13'd1, 13'($urandom_range(2, 4095)), 13'd4096};
		for (int ph = 0; ph < 4; ph++) begin
			write_chan_count(counts[ph]);
			for (int k = 0; k < 335; k++) begin
				quiet_out = (k >= 100 && k < 140);
				send_item(rand_item(), !(k >= 100 && k < 140));
			end
			quiet_out = 1'b0;
		end

		wait_cycles = 0;
		while (pending_stokes.size() != 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (80) @(negedge clk);
		if (fails == 0 && pending_stokes.size() == 0)
			$display("stokes_bandpass_normalizer_tb OK");
		else
			$display("stokes_bandpass_normalizer_tb NOT OK");
		$finish;
	end

endmodule
